// ===== src/vpd_pkg.sv =====
package vpd_pkg;

  localparam int unsigned MAX_UNIQUE = 1024;
  localparam int unsigned AW         = $clog2(MAX_UNIQUE);
  localparam int unsigned CW         = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned TOTAL_W    = 11;

  localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] INF_BITS = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pos_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    pos_t          wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [AW-1:0] idx;
    logic          is_new;
    logic          full;
    logic [CW-1:0] total;
  } res_t;

  // float equality on bit patterns: NaN never equal, +0 == -0
  function automatic logic float_eq(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    ma = a & ABS_MASK;
    mb = b & ABS_MASK;
    if (ma > INF_BITS || mb > INF_BITS) begin
      return 1'b0;
    end
    if (ma == '0 && mb == '0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic logic pos_eq(pos_t a, pos_t b);
    return float_eq(a.x, b.x) && float_eq(a.y, b.y) && float_eq(a.z, b.z);
  endfunction

endpackage

// ===== src/vpd_pos_ram.sv =====
module vpd_pos_ram
  import vpd_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output pos_t     rdata_o
);

  pos_t mem_q [MAX_UNIQUE];
  pos_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vpd_scan_ctrl.sv =====
module vpd_scan_ctrl
  import vpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     start_mesh_i,
  input  pos_t     pos_i,
  output ram_req_t ram_o,
  input  pos_t     rdata_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output res_t     res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_q, issue_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  pos_t          pos_q, pos_d;
  res_t          res_q, res_d;

  logic          accept;
  logic [CW-1:0] count_in;
  logic          hit;
  logic          last;
  logic          tbl_full;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign count_in = start_mesh_i ? '0 : count_q;
  assign hit      = pos_eq(rdata_i, pos_q);
  assign last     = ({1'b0, cmp_idx_q} == CW'(count_q - CW'(1)));
  assign tbl_full = (count_q == CW'(MAX_UNIQUE));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    cmp_idx_d = cmp_idx_q;
    pos_d     = pos_q;
    res_d     = res_q;
    ram_o     = '0;
    ram_o.wdata = pos_q;
    ram_o.waddr = count_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d   = pos_i;
          count_d = count_in;
          if (count_in == '0) begin
            // empty table: append straight away
            ram_o.we     = 1'b1;
            ram_o.waddr  = '0;
            ram_o.wdata  = pos_i;
            res_d.idx    = '0;
            res_d.is_new = 1'b1;
            res_d.full   = 1'b0;
            res_d.total  = CW'(1);
            count_d      = CW'(1);
            state_d      = ST_DONE;
          end else begin
            ram_o.re  = 1'b1;
            ram_o.raddr = '0;
            cmp_idx_d = '0;
            issue_d   = CW'(1);
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata_i holds entry cmp_idx_q; next entry is being read
        if (hit) begin
          res_d.idx    = cmp_idx_q;
          res_d.is_new = 1'b0;
          res_d.full   = 1'b0;
          res_d.total  = count_q;
          state_d      = ST_DONE;
        end else if (last) begin
          if (tbl_full) begin
            res_d.idx    = '0;
            res_d.is_new = 1'b0;
            res_d.full   = 1'b1;
            res_d.total  = count_q;
          end else begin
            ram_o.we     = 1'b1;
            res_d.idx    = count_q[AW-1:0];
            res_d.is_new = 1'b1;
            res_d.full   = 1'b0;
            res_d.total  = CW'(count_q + CW'(1));
            count_d      = CW'(count_q + CW'(1));
          end
          state_d = ST_DONE;
        end else begin
          ram_o.re    = (issue_q < count_q);
          ram_o.raddr = issue_q[AW-1:0];
          cmp_idx_d   = issue_q[AW-1:0];
          issue_d     = CW'(issue_q + CW'(1));
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      cmp_idx_q <= '0;
      pos_q     <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      cmp_idx_q <= cmp_idx_d;
      pos_q     <= pos_d;
      res_q     <= res_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_UNIQUE))
    else $error("unique count above table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, cmp_idx_q} < count_q))
    else $error("compare index beyond filled entries");

  a_new_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_new) |-> (res_o.total == CW'({1'b0, res_o.idx} + CW'(1))))
    else $error("appended entry not at end of table");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.full) |-> (tbl_full && !res_o.is_new))
    else $error("full flag without a full table");
`endif

endmodule

// ===== src/vertex_position_dedup_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  start_mesh_i, pos_x_i, pos_y_i, pos_z_i
// out      output     out_valid_o/out_ready_i vertex_index_o, is_new_o, table_full_o,
//                                            unique_total_o
//
// A request scans the stored entries in order until a hit or the last entry, at most
// MAX_UNIQUE of them; the single read port of the position RAM sets the pace, one
// 96-bit entry compared per cycle. An empty table is appended without a scan.
// Reset clears the unique count but not the RAM, which needs no clearing pass.
// A result waits in the output register, so the next request starts meanwhile;
// the scanner stalls only when a second result is ready and the first is not taken.
module vertex_position_dedup_unit
  import vpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_mesh_i,
  input  logic [31:0]        pos_x_i,
  input  logic [31:0]        pos_y_i,
  input  logic [31:0]        pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   vertex_index_o,
  output logic               is_new_o,
  output logic               table_full_o,
  output logic [TOTAL_W-1:0] unique_total_o
);

  pos_t     pos_in;
  ram_req_t ram_req;
  pos_t     ram_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic     out_valid_q;
  res_t     out_q;

  assign pos_in = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};

  vpd_pos_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  vpd_scan_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_mesh_i (start_mesh_i),
    .pos_i        (pos_in),
    .ram_o        (ram_req),
    .rdata_i      (ram_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = IDX_W'(out_q.idx);
  assign is_new_o       = out_q.is_new;
  assign table_full_o   = out_q.full;
  assign unique_total_o = TOTAL_W'(out_q.total);

endmodule

// ===== bench/vpd_weld_checker.sv =====
`timescale 1ns / 1ps

module vpd_weld_checker
  import vpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               start_mesh_i,
  input  logic [31:0]        pos_x_i,
  input  logic [31:0]        pos_y_i,
  input  logic [31:0]        pos_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [IDX_W-1:0]   vertex_index_i,
  input  logic               is_new_i,
  input  logic               table_full_i,
  input  logic [TOTAL_W-1:0] unique_total_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic               fresh;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } weld_answer_t;

  pos_t         welded_pos [MAX_UNIQUE];
  int unsigned  welded_cnt;
  weld_answer_t weld_answers_q[$];
  weld_answer_t want;

  function automatic bit coord_same(logic [31:0] a, logic [31:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    // signed zeros weld together
    if (a[30:0] == '0 && b[30:0] == '0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  // first-match search in insertion order, append on miss while room is left
  function automatic weld_answer_t weld_vertex(logic restart, pos_t p);
    weld_answer_t ans;
    bit           found;
    int unsigned  hit;
    if (restart) begin
      welded_cnt = 0;
    end
    found = 1'b0;
    hit   = 0;
    for (int unsigned j = 0; j < welded_cnt && !found; j++) begin
      if (coord_same(welded_pos[j].x, p.x) && coord_same(welded_pos[j].y, p.y) &&
          coord_same(welded_pos[j].z, p.z)) begin
        found = 1'b1;
        hit   = j;
      end
    end
    ans.fresh = 1'b0;
    ans.full  = 1'b0;
    if (found) begin
      ans.index = IDX_W'(hit);
    end else if (welded_cnt < MAX_UNIQUE) begin
      welded_pos[welded_cnt] = p;
      ans.index  = IDX_W'(welded_cnt);
      ans.fresh  = 1'b1;
      welded_cnt = welded_cnt + 1;
    end else begin
      ans.index = '0;
      ans.full  = 1'b1;
    end
    ans.total = TOTAL_W'(welded_cnt);
    return ans;
  endfunction

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      welded_cnt   = 0;
      fail_count_o = 0;
      weld_answers_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (weld_answers_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, actual index %0d new %0b full %0b total %0d",
                   $time, vertex_index_i, is_new_i, table_full_i, unique_total_i);
        end else begin
          want = weld_answers_q.pop_front();
          check_field("vertex_index", 32'(want.index), 32'(vertex_index_i));
          check_field("is_new", 32'(want.fresh), 32'(is_new_i));
          check_field("table_full", 32'(want.full), 32'(table_full_i));
          check_field("unique_total", 32'(want.total), 32'(unique_total_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        weld_answers_q.push_back(weld_vertex(start_mesh_i, pos_t'({pos_x_i, pos_y_i, pos_z_i})));
      end
    end
    outstanding_o = weld_answers_q.size();
  end

endmodule

// ===== bench/tb_vertex_position_dedup_unit.sv =====
`timescale 1ns / 1ps

module tb_vertex_position_dedup_unit;
  import vpd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 580;
  localparam int unsigned CALM_ITEMS     = 80;
  localparam int unsigned HOLD_AT        = 150;
  localparam int unsigned PAUSE_AT       = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               start_mesh;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic [31:0]        pos_z;
  logic               out_valid;
  logic               out_ready;
  logic [IDX_W-1:0]   vertex_index;
  logic               is_new;
  logic               table_full;
  logic [TOTAL_W-1:0] unique_total;

  int unsigned fail_count;
  int unsigned outstanding;
  bit          calm;
  bit          hold_req;
  logic [31:0] fill_z [MAX_UNIQUE];

  always #4 clk = ~clk;

  vertex_position_dedup_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_mesh_i   (start_mesh),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .vertex_index_o (vertex_index),
    .is_new_o       (is_new),
    .table_full_o   (table_full),
    .unique_total_o (unique_total)
  );

  vpd_weld_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .start_mesh_i   (start_mesh),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .vertex_index_i (vertex_index),
    .is_new_i       (is_new),
    .table_full_i   (table_full),
    .unique_total_i (unique_total),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // float corners: signed zeros, infinities, NaNs, extremes, denormals
  function automatic logic [31:0] corner_coord();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return 32'hFF80_0000;
      4:       return 32'h7FC0_0000;
      5:       return 32'h7F80_0001;
      6:       return 32'hFFFF_FFFF;
      7:       return 32'h3F80_0000;
      8:       return 32'h0000_0001;
      9:       return 32'h7F7F_FFFF;
      10:      return 32'hFF7F_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // called and returns at a falling edge; valid is left high after the request
  task automatic offer_vertex(logic restart, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    start_mesh <= restart;
    pos_x      <= x;
    pos_y      <= y;
    pos_z      <= z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned burst;
    bit          hold_done;
    burst     = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (burst > 0) begin
        out_ready <= 1'b0;
        burst--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("vertex_position_dedup_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    pos_t        mesh[$];
    pos_t        p;
    int unsigned sent;
    int unsigned mesh_len;
    int unsigned k;
    logic        restart;
    calm       = 1'b0;
    hold_req   = 1'b0;
    in_valid   = 1'b0;
    start_mesh = 1'b0;
    pos_x      = '0;
    pos_y      = '0;
    pos_z      = '0;
    rst_n      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    offer_vertex(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h8000_0000);
    offer_vertex(1'b0, 32'h7F80_0001, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_vertex(1'b0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001);
    offer_vertex(1'b0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001);
    offer_vertex(1'b0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000);
    offer_vertex(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000);
    offer_vertex(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    offer_vertex(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);

    // one mesh that fills the table: distinct x, z kept free of NaN for later hits
    for (int unsigned i = 0; i < MAX_UNIQUE; i++) begin
      fill_z[i] = $urandom() & 32'hBFFF_FFFF;
      offer_vertex(i == 0, 32'h3F80_0000 + i, 32'h4000_0000 | i, fill_z[i]);
    end
    offer_vertex(1'b0, 32'h3F80_0000 + MAX_UNIQUE - 1, 32'h4000_0000 | (MAX_UNIQUE - 1),
                 fill_z[MAX_UNIQUE-1]);
    offer_vertex(1'b0, 32'h3F80_0000 + 512, 32'h4000_0000 | 512, fill_z[512]);
    offer_vertex(1'b0, 32'h3F80_0000, 32'h4000_0000, fill_z[0]);
    offer_vertex(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_vertex(1'b0, 32'h7FC0_0000, 32'h4000_0000, fill_z[0]);
    offer_vertex(1'b0, 32'hC000_0000, 32'h8000_0000, 32'h7F80_0000);

    // random meshes, mostly short, with reuse of earlier positions to force hits
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mesh_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
      mesh.delete();
      k = 0;
      while (k < mesh_len && sent < RANDOM_ITEMS) begin
        restart = (k == 0) || ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if (mesh.size() > 0) begin
              p = mesh[$urandom_range(0, mesh.size() - 1)];
            end else begin
              p = {corner_coord(), corner_coord(), corner_coord()};
            end
            if (p.x[30:0] == '0) p.x[31] = 1'($urandom_range(0, 1));
            if (p.y[30:0] == '0) p.y[31] = 1'($urandom_range(0, 1));
            if (p.z[30:0] == '0) p.z[31] = 1'($urandom_range(0, 1));
          end
          4, 5, 6: p = {corner_coord(), corner_coord(), corner_coord()};
          default: p = {$urandom(), $urandom(), $urandom()};
        endcase
        if (RANDOM_ITEMS - sent <= CALM_ITEMS) begin
          calm = 1'b1;
        end
        offer_vertex(restart, p.x, p.y, p.z);
        mesh.push_back(p);
        sent++;
        k++;
        if (sent == HOLD_AT) begin
          hold_req = 1'b1;
        end
        if (sent == PAUSE_AT) begin
          in_valid <= 1'b0;
          wait (outstanding == 0);
          @(negedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    wait (outstanding == 0);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("vertex_position_dedup_unit regression: pass");
    end else begin
      $display("vertex_position_dedup_unit regression: fail");
    end
    $finish;
  end

endmodule
